// ----- src/cpch_pkg.sv -----
// Package for the counting pattern checker: widths, item types and Hamming helpers.
// Used by cpch_front, cpch_back and the top level.
`default_nettype none

package cpch_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TOTAL_WIDTH = 32;
  localparam logic [3:0] LOCK_RUN_RESET = 4'd5;

  // syndromes that point at a data bit, and the uncorrectable syndrome
  localparam logic [2:0] SYN_D0 = 3'd3;
  localparam logic [2:0] SYN_D1 = 3'd5;
  localparam logic [2:0] SYN_D2 = 3'd6;
  localparam logic [2:0] SYN_UNC = 3'd7;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [2:0] data;
    logic [2:0] value;
    logic       perr;
    logic       unc;
  } word_t;

  typedef struct packed {
    logic [2:0]             corrected_value;
    logic                   parity_error;
    logic                   uncorrectable;
    logic                   sequence_error;
    logic                   locked;
    logic [2:0]             expected_value;
    logic [TOTAL_WIDTH-1:0] parity_error_total;
    logic [TOTAL_WIDTH-1:0] sequence_error_total;
  } result_t;

  function automatic logic [2:0] parity_of(input logic [2:0] d);
    parity_of = {d[1] ^ d[2], d[0] ^ d[2], d[0] ^ d[1]};
  endfunction

  function automatic count_t sat_inc(input count_t c);
    sat_inc = (c == '1) ? c : c + count_t'(1);
  endfunction

endpackage

`default_nettype wire

// ----- src/cpch_front.sv -----
// Front end: syndrome decode and single-bit correction, then a two-entry item queue.
// Depends on cpch_pkg.
`default_nettype none

module cpch_front
  import cpch_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] link_byte,
  output logic            full,
  output logic            word_valid,
  output word_t           word,
  input  wire logic       word_take
);

  logic [2:0] data;
  logic [2:0] syn;
  word_t      cls;

  always_comb begin
    data = link_byte[4:2];
    syn = link_byte[7:5] ^ parity_of(data);
    cls.data = data;
    cls.perr = (syn != 3'd0);
    cls.unc = (syn == SYN_UNC);
    unique case (syn)
      SYN_D0:  cls.value = data ^ 3'b001;
      SYN_D1:  cls.value = data ^ 3'b010;
      SYN_D2:  cls.value = data ^ 3'b100;
      default: cls.value = data;
    endcase
  end

  word_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  assign full = (count == 2'd2);
  assign word_valid = (count != 2'd0);
  assign word = slot[rd_ptr];
  assign wr_en = push && !full;
  assign rd_en = word_take && word_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/cpch_back.sv -----
// Back end: hunt/lock tracking, sequence check, saturating error counts, result queue.
// Depends on cpch_pkg.
`default_nettype none

module cpch_back
  import cpch_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       lock_run_we,
  input  wire logic [3:0] lock_run,
  input  wire logic       word_valid,
  input  wire word_t      word,
  output logic            word_take,
  output logic            empty,
  output result_t         result,
  input  wire logic       pop
);

  logic       [3:0] lock_run_reg;
  logic             lock_flag;
  logic       [3:0] run_length;
  logic       [2:0] hunt_pattern;
  logic       [2:0] expected_counter;
  count_t           parity_error_count;
  count_t           sequence_error_count;

  logic             lock_flag_next;
  logic       [3:0] run_length_next;
  logic       [2:0] hunt_pattern_next;
  logic       [2:0] expected_counter_next;
  count_t           parity_error_count_next;
  count_t           sequence_error_count_next;

  logic       [3:0] need;
  logic       [2:0] pattern_adv;
  logic             serr;
  result_t          res;

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       rd_en;

  assign word_take = word_valid && (count != 2'd2);
  assign empty = (count == 2'd0);
  assign result = slot[rd_ptr];
  assign rd_en = pop && !empty;

  always_comb begin
    need = (lock_run_reg == 4'd0) ? 4'd1 : lock_run_reg;
    pattern_adv = (run_length == 4'd0) ? word.data : hunt_pattern + 3'd1;
    serr = lock_flag && !word.unc && (word.value != expected_counter);

    lock_flag_next = lock_flag;
    run_length_next = run_length;
    hunt_pattern_next = hunt_pattern;
    expected_counter_next = expected_counter;
    parity_error_count_next = word.perr ? sat_inc(parity_error_count) : parity_error_count;
    sequence_error_count_next = serr ? sat_inc(sequence_error_count) : sequence_error_count;

    priority if (lock_flag) begin
      expected_counter_next = expected_counter + 3'd1;
    end else if (word.perr) begin
      run_length_next = 4'd0;
    end else begin
      // on a match or a restart the pattern ends up equal to the data
      hunt_pattern_next = word.data;
      run_length_next = (word.data == pattern_adv) ? run_length + 4'd1 : 4'd0;
      if (run_length_next == need) begin
        lock_flag_next = 1'b1;
        expected_counter_next = word.data + 3'd1;
      end
    end

    res.corrected_value = word.value;
    res.parity_error = word.perr;
    res.uncorrectable = word.unc;
    res.sequence_error = serr;
    res.locked = lock_flag;
    res.expected_value = lock_flag ? expected_counter : 3'd0;
    res.parity_error_total = TOTAL_WIDTH'(parity_error_count_next);
    res.sequence_error_total = TOTAL_WIDTH'(sequence_error_count_next);
  end

  always_ff @(posedge clk) begin
    if (word_take) begin
      slot[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_run_reg <= LOCK_RUN_RESET;
      lock_flag <= 1'b0;
      run_length <= 4'd0;
      hunt_pattern <= 3'd0;
      expected_counter <= 3'd0;
      parity_error_count <= '0;
      sequence_error_count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (lock_run_we) begin
        lock_run_reg <= lock_run;
      end
      if (word_take) begin
        lock_flag <= lock_flag_next;
        run_length <= run_length_next;
        hunt_pattern <= hunt_pattern_next;
        expected_counter <= expected_counter_next;
        parity_error_count <= parity_error_count_next;
        sequence_error_count <= sequence_error_count_next;
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({word_take, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/counting_pattern_checker_hamming.sv -----
// Counting pattern link checker with Hamming (6,3) correction.
// An item pushed is registered first in the front queue, then in the result queue, before it is
// visible on the result ports (one register stage in the front queue, one in the result queue).
// Throughput: one item per cycle while the queues are not full; front and back each carry a two-entry queue.
// Reset (rst, synchronous): queues empty, hunting, counts zero, lock_run back to 5.
// Depends on cpch_pkg, cpch_front, cpch_back.
`default_nettype none

module counting_pattern_checker_hamming
  import cpch_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   lock_run_we,
  input  wire logic [3:0]             lock_run,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [7:0]             link_byte,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [2:0]                  corrected_value,
  output logic                        parity_error,
  output logic                        uncorrectable,
  output logic                        sequence_error,
  output logic                        locked,
  output logic [2:0]                  expected_value,
  output logic [TOTAL_WIDTH-1:0]      parity_error_total,
  output logic [TOTAL_WIDTH-1:0]      sequence_error_total
);

  logic    word_valid;
  logic    word_take;
  word_t   word;
  result_t result;

  cpch_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .link_byte  (link_byte),
    .full       (full),
    .word_valid (word_valid),
    .word       (word),
    .word_take  (word_take)
  );

  cpch_back u_back (
    .clk         (clk),
    .rst         (rst),
    .lock_run_we (lock_run_we),
    .lock_run    (lock_run),
    .word_valid  (word_valid),
    .word        (word),
    .word_take   (word_take),
    .empty       (empty),
    .result      (result),
    .pop         (pop)
  );

  assign corrected_value = result.corrected_value;
  assign parity_error = result.parity_error;
  assign uncorrectable = result.uncorrectable;
  assign sequence_error = result.sequence_error;
  assign locked = result.locked;
  assign expected_value = result.expected_value;
  assign parity_error_total = result.parity_error_total;
  assign sequence_error_total = result.sequence_error_total;

endmodule

`default_nettype wire
